### sv/pcs_pkg.sv
// Shared types, constants and codes of the PTP clock servo.
`default_nettype none
package pcs_pkg;

    localparam int  FRAC_BITS     = 16;
    localparam longint NS_PER_SECOND = 1000000000;
    localparam int  NS_BITS       = $clog2(NS_PER_SECOND);
    localparam int  TS_W          = 63;
    localparam int  T_W           = 64;
    localparam int  DRIFT_W       = 48;
    localparam int  MUL_W         = T_W + NS_BITS;
    localparam int  DIV_W         = MUL_W + FRAC_BITS;
    localparam int  CNT_W         = $clog2(DIV_W + 1);
    localparam int  LOCK_W        = 32;

    localparam int  S_TDATA_W     = 384;
    localparam int  M_FREQ_LO     = 0;
    localparam int  M_STEP_LO     = M_FREQ_LO + DRIFT_W;
    localparam int  M_OFS_LO      = M_STEP_LO + T_W;
    localparam int  M_DLY_LO      = M_OFS_LO + T_W;
    localparam int  M_DRIFT_LO    = M_DLY_LO + TS_W;
    localparam int  M_LOCK_LO     = M_DRIFT_LO + DRIFT_W;
    localparam int  M_FIELDS_W    = M_LOCK_LO + LOCK_W;
    localparam int  M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int  CFG_IDX_W     = 3;
    localparam int  CFG_W         = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_E2E  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P2P  = 3'd4;

    localparam logic [15:0] E2E_TRIM_RST = 16'hFF38;   // -200 ns
    localparam logic [15:0] P2P_TRIM_RST = 16'd500;

    localparam logic [T_W-1:0] S64_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic [T_W-1:0] S64_MIN = {1'b1, {(T_W-1){1'b0}}};
    localparam logic [DRIFT_W-1:0] S48_MAX = {1'b0, {(DRIFT_W-1){1'b1}}};
    localparam logic [DRIFT_W-1:0] S48_MIN = {1'b1, {(DRIFT_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] STEP_LIM = 64'sd1000;
    localparam logic signed [T_W-1:0] LOCK_LIM = 64'sd100;
    localparam logic [T_W-1:0] DRIFT_ERR_LIM  = T_W'(100000) << FRAC_BITS;
    localparam logic [T_W-1:0] DRIFT_FREQ_LIM = T_W'(1000) << FRAC_BITS;
    localparam logic [T_W-1:0] DRIFT_MOD      = T_W'(NS_PER_SECOND) << FRAC_BITS;
    localparam logic [T_W-1:0] KI_LIM         = T_W'(1) << 60;

    typedef enum logic [2:0] {
        ACT_NOHIST = 3'd0,
        ACT_ERR    = 3'd1,
        ACT_FREQ   = 3'd2,
        ACT_STEP   = 3'd3,
        ACT_FINE   = 3'd4
    } t_action;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIFF, OP_DELAY, OP_OFS1, OP_OFS2, OP_NOHIST,
        OP_MUL_INIT, OP_MUL_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DRIFT,
        OP_ERR, OP_FREQ, OP_STEP, OP_FINE_INT, OP_FINE_MAG, OP_FINE_LO,
        OP_FINE_HI, OP_FINE_SAT, OP_FINE_SUM, OP_FINE_END
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic prev_valid;
        logic mul_last;
        logic div_last;
        logic drift_err;
        logic freq_sel;
        logic step_sel;
    } t_sts;

endpackage
`default_nettype wire

### sv/pcs_ctrl.sv
// Sequencer of the clock servo: steps the datapath through one exchange.
`default_nettype none
module pcs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire pcs_pkg::t_sts i_sts,
    output pcs_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_DELAY, S_OFS1, S_OFS2, S_NOHIST, S_MINIT, S_MUL,
        S_DINIT, S_DIV, S_DRIFT, S_DECIDE, S_FMAG, S_FLO, S_FHI, S_FSAT,
        S_FSUM, S_FEND, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        o_cmd.op     = pcs_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = pcs_pkg::OP_LOAD;
                    n_state  = S_DIFF;
                end
            end
            S_DIFF:  begin o_cmd.op = pcs_pkg::OP_DIFF;  n_state = S_DELAY; end
            S_DELAY: begin o_cmd.op = pcs_pkg::OP_DELAY; n_state = S_OFS1; end
            S_OFS1:  begin o_cmd.op = pcs_pkg::OP_OFS1;  n_state = S_OFS2; end
            S_OFS2: begin
                o_cmd.op = pcs_pkg::OP_OFS2;
                n_state  = i_sts.prev_valid ? S_MINIT : S_NOHIST;
            end
            S_NOHIST: begin o_cmd.op = pcs_pkg::OP_NOHIST; n_state = S_DONE; end
            S_MINIT:  begin o_cmd.op = pcs_pkg::OP_MUL_INIT; n_state = S_MUL; end
            S_MUL: begin
                o_cmd.op = pcs_pkg::OP_MUL_STEP;
                if (i_sts.mul_last) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin o_cmd.op = pcs_pkg::OP_DIV_INIT; n_state = S_DIV; end
            S_DIV: begin
                o_cmd.op = pcs_pkg::OP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_DRIFT;
                end
            end
            S_DRIFT: begin o_cmd.op = pcs_pkg::OP_DRIFT; n_state = S_DECIDE; end
            S_DECIDE: begin
                if (i_sts.drift_err) begin
                    o_cmd.op = pcs_pkg::OP_ERR;
                    n_state  = S_DONE;
                end else if (i_sts.freq_sel) begin
                    o_cmd.op = pcs_pkg::OP_FREQ;
                    n_state  = S_DONE;
                end else if (i_sts.step_sel) begin
                    o_cmd.op = pcs_pkg::OP_STEP;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = pcs_pkg::OP_FINE_INT;
                    n_state  = S_FMAG;
                end
            end
            S_FMAG: begin o_cmd.op = pcs_pkg::OP_FINE_MAG; n_state = S_FLO; end
            S_FLO:  begin o_cmd.op = pcs_pkg::OP_FINE_LO;  n_state = S_FHI; end
            S_FHI:  begin o_cmd.op = pcs_pkg::OP_FINE_HI;  n_state = S_FSAT; end
            S_FSAT: begin o_cmd.op = pcs_pkg::OP_FINE_SAT; n_state = S_FSUM; end
            S_FSUM: begin o_cmd.op = pcs_pkg::OP_FINE_SUM; n_state = S_FEND; end
            S_FEND: begin o_cmd.op = pcs_pkg::OP_FINE_END; n_state = S_DONE; end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;

endmodule
`default_nettype wire

### sv/pcs_dp.sv
// Datapath of the clock servo: offsets, drift divider, PI terms and state.
`default_nettype none
module pcs_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pcs_pkg::t_cmd                   i_cmd,
    output pcs_pkg::t_sts                        o_sts,
    input  wire logic                            i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pcs_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic [pcs_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                            i_s_tuser,
    output logic [pcs_pkg::M_TDATA_W-1:0]        o_m_tdata,
    output logic [2:0]                           o_m_tuser
);

    localparam int TW = pcs_pkg::T_W;
    localparam int TS = pcs_pkg::TS_W;
    localparam int DW = pcs_pkg::DRIFT_W;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {a[TW-1], a} + {b[TW-1], b};
        if (s[TW] != s[TW-1]) begin
            sat_add = s[TW] ? pcs_pkg::S64_MIN : pcs_pkg::S64_MAX;
        end else begin
            sat_add = s[TW-1:0];
        end
    endfunction

    function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {a[TW-1], a} - {b[TW-1], b};
        if (s[TW] != s[TW-1]) begin
            sat_sub = s[TW] ? pcs_pkg::S64_MIN : pcs_pkg::S64_MAX;
        end else begin
            sat_sub = s[TW-1:0];
        end
    endfunction

    function automatic logic [TW-1:0] mag(input logic [TW-1:0] v);
        mag = v[TW-1] ? (~v + TW'(1)) : v;
    endfunction

    function automatic logic [DW-1:0] clamp48(input logic [TW-1:0] v);
        if (v[TW-1:DW-1] == {(TW-DW+1){1'b0}} || v[TW-1:DW-1] == {(TW-DW+1){1'b1}}) begin
            clamp48 = v[DW-1:0];
        end else begin
            clamp48 = v[TW-1] ? pcs_pkg::S48_MIN : pcs_pkg::S48_MAX;
        end
    endfunction

    // configuration
    logic [23:0] r_kp, r_ki;
    logic        r_mode;
    logic [15:0] r_e2e, r_p2p;

    // servo state
    logic [TW-1:0] r_prev_send, r_prev_recv, r_integral;
    logic          r_prev_valid;
    logic [DW-1:0] r_drift_est;
    logic [pcs_pkg::LOCK_W-1:0] r_lock;
    logic [pcs_pkg::CNT_W-1:0]  r_cnt;
    logic r_err, r_fsel, r_big, r_small;

    // work registers
    logic          r_cmd;
    logic [TS-1:0] r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;
    logic [TW-1:0] r_a, r_b, r_dts, r_d1, r_d2, r_delay, r_num, r_o1, r_offset, r_corr;
    logic [TW-1:0] r_num_mag, r_dmag;
    logic          r_neg, r_d1_zero;
    logic [pcs_pkg::MUL_W-1:0]   r_prod, r_mcand;
    logic [pcs_pkg::NS_BITS-1:0] r_mplier;
    logic [pcs_pkg::DIV_W-1:0]   r_dvd;
    logic [TW-1:0] r_rem;
    logic [DW-1:0] r_drift;
    logic [39:0]   r_kp_prod;
    logic [TW-1:0] r_imag, r_ki_term, r_sum;
    logic [23:0]   r_kmag;
    logic          r_kneg;
    logic [55:0]   r_pp_lo, r_pp_hi;
    pcs_pkg::t_action r_res_action;
    logic [DW-1:0] r_res_freq;
    logic [TW-1:0] r_res_step;
    logic [pcs_pkg::M_TDATA_W-1:0] r_m_tdata;
    logic [2:0]    r_m_tuser;

    // combinational helpers
    logic [TW-1:0] c_trim, c_ofs, c_half, c_dsub, c_new_recv, c_ki_mag;
    logic [TW:0]   c_rs;
    logic          c_ge;
    logic [pcs_pkg::DIV_W-1:0] c_lim, c_q;
    logic [DW-1:0] c_qm;
    logic [TW-1:0] c_fsum, c_fwrap;
    logic [87:0]   c_ki_prod;
    logic [pcs_pkg::LOCK_W-1:0] c_lock_inc;

    always_comb begin
        c_trim = r_mode ? {{(TW-16){r_p2p[15]}}, r_p2p} : {{(TW-16){r_e2e[15]}}, r_e2e};
        c_ofs  = r_cmd ? r_dts : sat_add(r_o1, c_trim);
        if (c_ofs == pcs_pkg::S64_MIN) begin
            c_ofs = pcs_pkg::S64_MIN + TW'(1);
        end
        c_dsub = sat_sub(r_a, r_b);
        // truncate toward zero
        c_half = c_dsub + {{(TW-1){1'b0}}, c_dsub[TW-1]};
        c_rs   = {r_rem, r_dvd[pcs_pkg::DIV_W-1]};
        c_ge   = c_rs >= {1'b0, r_dmag};
        c_lim  = r_neg ? pcs_pkg::DIV_W'(pcs_pkg::S48_MIN) : pcs_pkg::DIV_W'(pcs_pkg::S48_MAX);
        c_q    = (r_dvd > c_lim) ? c_lim : r_dvd;
        c_qm   = c_q[DW-1:0];
        c_fsum = {{(TW-DW){r_drift_est[DW-1]}}, r_drift_est}
               + {{(TW-DW){r_drift[DW-1]}}, r_drift};
        if (!c_fsum[TW-1] && c_fsum >= pcs_pkg::DRIFT_MOD) begin
            c_fwrap = c_fsum - pcs_pkg::DRIFT_MOD;
        end else if (c_fsum[TW-1] && (~c_fsum + TW'(1)) >= pcs_pkg::DRIFT_MOD) begin
            c_fwrap = c_fsum + pcs_pkg::DRIFT_MOD;
        end else begin
            c_fwrap = c_fsum;
        end
        c_ki_prod = {r_pp_hi, 32'b0} + {32'b0, r_pp_lo};
        c_ki_mag  = (c_ki_prod > 88'(pcs_pkg::KI_LIM)) ? pcs_pkg::KI_LIM : c_ki_prod[TW-1:0];
        c_new_recv = {1'b0, r_t2} + r_corr;
        c_lock_inc = (r_lock == {pcs_pkg::LOCK_W{1'b1}}) ? r_lock
                   : r_lock + pcs_pkg::LOCK_W'(1);
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= '0;
            r_ki         <= '0;
            r_mode       <= 1'b0;
            r_e2e        <= pcs_pkg::E2E_TRIM_RST;
            r_p2p        <= pcs_pkg::P2P_TRIM_RST;
            r_prev_send  <= '0;
            r_prev_recv  <= '0;
            r_prev_valid <= 1'b0;
            r_drift_est  <= '0;
            r_integral   <= '0;
            r_lock       <= '0;
            r_cnt        <= '0;
            r_err        <= 1'b0;
            r_fsel       <= 1'b0;
            r_big        <= 1'b0;
            r_small      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pcs_pkg::CFG_KP:   r_kp   <= i_cfg_data;
                    pcs_pkg::CFG_KI:   r_ki   <= i_cfg_data;
                    pcs_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                    pcs_pkg::CFG_E2E:  r_e2e  <= i_cfg_data[15:0];
                    pcs_pkg::CFG_P2P:  r_p2p  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                pcs_pkg::OP_MUL_INIT: begin
                    r_cnt   <= '0;
                    r_big   <= ($signed(r_offset) > pcs_pkg::STEP_LIM)
                            || ($signed(r_offset) < -pcs_pkg::STEP_LIM);
                    r_small <= ($signed(r_offset) < pcs_pkg::LOCK_LIM)
                            && ($signed(r_offset) > -pcs_pkg::LOCK_LIM);
                end
                pcs_pkg::OP_MUL_STEP: r_cnt <= r_cnt + pcs_pkg::CNT_W'(1);
                pcs_pkg::OP_DIV_INIT: r_cnt <= '0;
                pcs_pkg::OP_DIV_STEP: r_cnt <= r_cnt + pcs_pkg::CNT_W'(1);
                pcs_pkg::OP_DRIFT: begin
                    r_err  <= r_d1_zero || (TW'(c_qm) > pcs_pkg::DRIFT_ERR_LIM);
                    r_fsel <= TW'(c_qm) > pcs_pkg::DRIFT_FREQ_LIM;
                end
                pcs_pkg::OP_NOHIST: begin
                    r_prev_send  <= {1'b0, r_t1};
                    r_prev_recv  <= {1'b0, r_t2};
                    r_prev_valid <= 1'b1;
                end
                pcs_pkg::OP_ERR: begin
                    r_lock       <= '0;
                    r_prev_send  <= {1'b0, r_t1};
                    r_prev_recv  <= {1'b0, r_t2};
                end
                pcs_pkg::OP_FREQ: begin
                    r_drift_est  <= clamp48(c_fwrap);
                    r_integral   <= '0;
                    r_lock       <= '0;
                    r_prev_send  <= {1'b0, r_t1};
                    r_prev_recv  <= {1'b0, r_t2};
                end
                pcs_pkg::OP_STEP: begin
                    r_integral   <= '0;
                    r_lock       <= '0;
                    r_prev_send  <= {1'b0, r_t1};
                    r_prev_recv  <= c_new_recv;
                end
                pcs_pkg::OP_FINE_INT: r_integral <= sat_add(r_integral, r_corr);
                pcs_pkg::OP_FINE_END: begin
                    r_lock       <= r_small ? c_lock_inc : '0;
                    r_prev_send  <= {1'b0, r_t1};
                    r_prev_recv  <= c_new_recv;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pcs_pkg::OP_LOAD: begin
                r_cmd <= i_s_tuser;
                r_t1  <= i_s_tdata[0*TS +: TS];
                r_t2  <= i_s_tdata[1*TS +: TS];
                r_t3  <= i_s_tdata[2*TS +: TS];
                r_t4  <= i_s_tdata[3*TS +: TS];
                r_t5  <= i_s_tdata[4*TS +: TS];
                r_t6  <= i_s_tdata[5*TS +: TS];
            end
            pcs_pkg::OP_DIFF: begin
                r_a   <= r_mode ? ({1'b0, r_t6} - {1'b0, r_t3}) : ({1'b0, r_t4} - {1'b0, r_t1});
                r_b   <= r_mode ? ({1'b0, r_t5} - {1'b0, r_t4}) : ({1'b0, r_t3} - {1'b0, r_t2});
                r_dts <= {1'b0, r_t2} - {1'b0, r_t1};
                r_d1  <= {1'b0, r_t1} - r_prev_send;
                r_d2  <= {1'b0, r_t2} - r_prev_recv;
            end
            pcs_pkg::OP_DELAY: begin
                r_delay <= r_cmd ? '0 : {c_half[TW-1], c_half[TW-1:1]};
                r_num   <= sat_sub(r_d1, r_d2);
            end
            pcs_pkg::OP_OFS1: begin
                r_o1      <= sat_sub(r_dts, r_delay);
                r_num_mag <= mag(r_num);
                r_dmag    <= mag(r_d1);
                r_neg     <= r_num[TW-1] != r_d1[TW-1];
                r_d1_zero <= r_d1 == '0;
            end
            pcs_pkg::OP_OFS2: r_offset <= c_ofs;
            pcs_pkg::OP_NOHIST: begin
                r_res_action <= pcs_pkg::ACT_NOHIST;
                r_res_freq   <= '0;
                r_res_step   <= '0;
                r_drift      <= '0;
            end
            pcs_pkg::OP_MUL_INIT: begin
                r_corr   <= ~r_offset + TW'(1);
                r_prod   <= '0;
                r_mcand  <= pcs_pkg::MUL_W'(r_num_mag);
                r_mplier <= pcs_pkg::NS_BITS'(pcs_pkg::NS_PER_SECOND);
            end
            pcs_pkg::OP_MUL_STEP: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= {r_mcand[pcs_pkg::MUL_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[pcs_pkg::NS_BITS-1:1]};
            end
            pcs_pkg::OP_DIV_INIT: begin
                r_dvd <= {r_prod, {pcs_pkg::FRAC_BITS{1'b0}}};
                r_rem <= '0;
            end
            pcs_pkg::OP_DIV_STEP: begin
                // restoring step: quotient bits shift in at the bottom
                r_rem <= c_ge ? TW'(c_rs - {1'b0, r_dmag}) : c_rs[TW-1:0];
                r_dvd <= {r_dvd[pcs_pkg::DIV_W-2:0], c_ge};
            end
            pcs_pkg::OP_DRIFT: begin
                if (r_d1_zero) begin
                    r_drift <= '0;
                end else begin
                    r_drift <= r_neg ? (~c_qm + DW'(1)) : c_qm;
                end
            end
            pcs_pkg::OP_ERR: begin
                r_res_action <= pcs_pkg::ACT_ERR;
                r_res_freq   <= '0;
                r_res_step   <= '0;
            end
            pcs_pkg::OP_FREQ: begin
                r_res_action <= pcs_pkg::ACT_FREQ;
                r_res_freq   <= clamp48(c_fwrap);
                r_res_step   <= '0;
            end
            pcs_pkg::OP_STEP: begin
                r_res_action <= pcs_pkg::ACT_STEP;
                r_res_freq   <= '0;
                r_res_step   <= r_corr;
            end
            pcs_pkg::OP_FINE_INT: begin
                r_kp_prod <= $signed({{24{r_corr[15]}}, r_corr[15:0]})
                           * $signed({{16{r_kp[23]}}, r_kp});
            end
            pcs_pkg::OP_FINE_MAG: begin
                r_imag <= mag(r_integral);
                r_kmag <= r_ki[23] ? (~r_ki + 24'd1) : r_ki;
                r_kneg <= r_integral[TW-1] != r_ki[23];
            end
            pcs_pkg::OP_FINE_LO: r_pp_lo <= 56'(r_imag[31:0]) * 56'(r_kmag);
            pcs_pkg::OP_FINE_HI: r_pp_hi <= 56'(r_imag[63:32]) * 56'(r_kmag);
            pcs_pkg::OP_FINE_SAT: r_ki_term <= r_kneg ? (~c_ki_mag + TW'(1)) : c_ki_mag;
            pcs_pkg::OP_FINE_SUM: begin
                r_sum <= {{(TW-DW){r_drift_est[DW-1]}}, r_drift_est}
                       + {{(TW-40){r_kp_prod[39]}}, r_kp_prod} + r_ki_term;
            end
            pcs_pkg::OP_FINE_END: begin
                r_res_action <= pcs_pkg::ACT_FINE;
                r_res_freq   <= clamp48(r_sum);
                r_res_step   <= '0;
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_m_tdata <= pcs_pkg::M_TDATA_W'({r_lock, r_drift, r_delay[TS-1:0],
                                              r_offset, r_res_step, r_res_freq});
            r_m_tuser <= r_res_action;
        end
    end

    assign o_sts.prev_valid = r_prev_valid;
    assign o_sts.mul_last   = r_cnt == pcs_pkg::CNT_W'(pcs_pkg::NS_BITS - 1);
    assign o_sts.div_last   = r_cnt == pcs_pkg::CNT_W'(pcs_pkg::DIV_W - 1);
    assign o_sts.drift_err  = r_err;
    assign o_sts.freq_sel   = r_fsel;
    assign o_sts.step_sel   = r_big;
    assign o_m_tdata        = r_m_tdata;
    assign o_m_tuser        = r_m_tuser;

endmodule
`default_nettype wire

### sv/ptp_clock_servo_top.sv
// PTP PI clock servo: top level joining the sequencer and the datapath.
//
// Slave stream: one word per exchange; tdata holds t1..t6 (63 bits each,
// t1 lowest), tuser is the command (0 two-way sync, 1 PPS pair).
// Master stream: one word per exchange; tuser is the action code, tdata
// holds freq_adjust, offset_step, offset, path_delay, measured_drift and
// lock_run_count from the lowest bit up.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 kp, 1 ki, 2 peer mode, 3 e2e trim, 4 p2p trim) at the clock edge.
// One exchange at a time: o_s_tready is high only while idle. A result
// waits on the bit-serial 30-step multiply by one second and the 110-step
// restoring drift divide, except when there is no history yet; a fine PI
// update adds its own PI steps. The next word can be taken in the cycle
// after the result is loaded.
// A stalled master holds its word; the finished result waits inside until
// the output register frees. Synchronous reset clears history, servo state,
// the output valid and restores the register defaults.
`default_nettype none
module ptp_clock_servo_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // t1, t2, t3, t4, t5, t6, zero pad
    input  wire logic [pcs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  wire logic                          i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // freq_adjust, offset_step, offset, path_delay, measured_drift,
    // lock_run_count, zero pad
    output logic [pcs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // action
    output logic [2:0]                         o_m_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pcs_pkg::CFG_W-1:0]     i_cfg_data
);

    pcs_pkg::t_cmd cmd;
    pcs_pkg::t_sts sts;

    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
`default_nettype wire

### sv/pcs_checker.sv
// Port-level checks of the clock servo, bound to the top level.
`default_nettype none
module pcs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          i_s_tready,
    input wire logic                          i_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [pcs_pkg::M_TDATA_W-1:0] i_m_tdata,
    input wire logic [2:0]                    i_m_tuser
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input taken while an exchange is in work");

    a_step_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser != pcs_pkg::ACT_STEP
        |-> i_m_tdata[pcs_pkg::M_OFS_LO-1:pcs_pkg::M_STEP_LO] == '0)
        else $error("step value outside a step action");

    a_freq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == pcs_pkg::ACT_NOHIST || i_m_tuser == pcs_pkg::ACT_ERR
                       || i_m_tuser == pcs_pkg::ACT_STEP)
        |-> i_m_tdata[pcs_pkg::M_STEP_LO-1:pcs_pkg::M_FREQ_LO] == '0)
        else $error("frequency trim without a frequency action");

endmodule

bind ptp_clock_servo_top pcs_checker u_pcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
`default_nettype wire
